// ===== design/fifo_fair_reader_writer_lock_core_assert.svh =====
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_lock_core_assert.svh
// Assertion macros for the reader-writer lock arbiter, clocked on clk with
// the asynchronous active-low reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef FIFO_FAIR_READER_WRITER_LOCK_CORE_ASSERT_SVH
`define FIFO_FAIR_READER_WRITER_LOCK_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define FRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock core check failed");

// Check that the consequent holds in the cycle after the antecedent
`define FRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock core check failed");

`endif

// ===== design/frl_pkg.sv =====
// ----------------------------------------------------------------------------
// frl_pkg
// Shared constants, codes and types of the FIFO-fair reader-writer lock.
// ----------------------------------------------------------------------------
package frl_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_READERS = 255;
    localparam int MAX_OUT     = 16;
    localparam int ID_W        = 8;

    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RCNT_W = $clog2(MAX_READERS + 1);
    localparam int DRN_W  = $clog2(MAX_OUT + 1);

    // Input operation codes
    typedef enum logic [1:0] {
        OP_LOCK           = 2'd0,
        OP_RELEASE_EXCL   = 2'd1,
        OP_RELEASE_SHARED = 2'd2
    } op_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_GRANTED   = 3'd0,
        KIND_QUEUED    = 3'd1,
        KIND_RESUMED   = 3'd2,
        KIND_NONE      = 3'd3,
        KIND_REJECTED  = 3'd4,
        KIND_PROTO_ERR = 3'd5
    } kind_t;

    // One waiter in the queue
    typedef struct packed {
        logic            excl;
        logic [ID_W-1:0] id;
    } q_entry_t;

    // Queue commands from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    // Queue status back to the sequencer
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
        logic              full;
    } q_stat_t;

endpackage

// ===== design/fifo_fair_reader_writer_lock_core.sv =====
// Timing: a request that drains nothing registers its word in the decide state once the
// output is free; a draining release passes through a read and an evaluate state for each
// resumed waiter, because the head entry comes from a registered memory read. One item at
// a time: in_stall holds new requests off until the sequencer is back in idle.
// Reset: asynchronous active-low rst_n clears lock state, queue pointers and
// output valid; queue entries are never cleared and are used only once written.
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_lock_core
// Reader-writer lock arbiter with a FIFO wait queue, driven by a small
// sequencer that pops and checks one waiter at a time.
// ----------------------------------------------------------------------------
`include "fifo_fair_reader_writer_lock_core_assert.svh"

module fifo_fair_reader_writer_lock_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                op,
    input  logic [frl_pkg::ID_W-1:0]  requester_id,
    input  logic                      want_exclusive,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                kind,
    output logic [frl_pkg::ID_W-1:0]  resumed_id,
    output logic                      resumed_exclusive,
    output logic                      last
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_READ   = 4'b0100,
        S_EVAL   = 4'b1000
    } state_t;

    localparam logic [frl_pkg::RCNT_W-1:0] RC_MAX = frl_pkg::RCNT_W'(frl_pkg::MAX_READERS);
    localparam logic [frl_pkg::DRN_W-1:0]  N_MAX  = frl_pkg::DRN_W'(frl_pkg::MAX_OUT);

    state_t                      state_reg, state_next;
    logic [1:0]                  op_reg, op_next;
    frl_pkg::q_entry_t           req_reg, req_next;
    logic                        wa_reg, wa_next;
    logic [frl_pkg::RCNT_W-1:0]  rc_reg, rc_next;
    logic [frl_pkg::DRN_W-1:0]   n_reg, n_next;
    logic                        pend_valid_reg, pend_valid_next;
    frl_pkg::q_entry_t           pend_reg, pend_next;
    logic                        out_valid_reg, out_valid_next;
    frl_pkg::kind_t              kind_reg;
    logic [frl_pkg::ID_W-1:0]    rid_reg;
    logic                        rexcl_reg;
    logic                        last_reg;

    frl_pkg::q_ctrl_t            q_ctrl;
    frl_pkg::q_entry_t           q_head;
    frl_pkg::q_stat_t            q_stat;

    logic                        out_free;
    logic                        emit;
    frl_pkg::kind_t              e_kind;
    logic [frl_pkg::ID_W-1:0]    e_id;
    logic                        e_excl;
    logic                        e_last;
    logic                        rc_at_max;
    logic                        grant_ok;
    logic                        eligible;
    logic                        cont;
    logic                        chk_depth_ok;
    logic                        chk_plain_word;
    logic                        chk_plain_ok;

    frl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (q_ctrl),
        .push_entry (req_reg),
        .head_entry (q_head),
        .stat       (q_stat)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign rc_at_max = (rc_reg >= RC_MAX);
    assign grant_ok  = !wa_reg && q_stat.empty && (!req_reg.excl || (rc_reg == '0));

    // Check of the head waiter against the lock state
    assign eligible = q_head.excl ? (rc_reg == '0) : !rc_at_max;
    assign cont     = !q_stat.empty && !wa_reg && (n_reg < N_MAX) && eligible;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        wa_next         = wa_reg;
        rc_next         = rc_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        q_ctrl          = '0;
        emit            = 1'b0;
        e_kind          = frl_pkg::KIND_NONE;
        e_id            = '0;
        e_excl          = 1'b0;
        e_last          = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take the next input word
                if (in_valid)
                begin
                    op_next      = op;
                    req_next.id   = requester_id;
                    req_next.excl = want_exclusive;
                    state_next   = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                unique case (op_reg)
                    frl_pkg::OP_LOCK:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (grant_ok)
                            begin
                                if (req_reg.excl)
                                begin
                                    wa_next = 1'b1;
                                    e_kind  = frl_pkg::KIND_GRANTED;
                                end
                                else if (rc_at_max)
                                begin
                                    e_kind = frl_pkg::KIND_REJECTED;
                                end
                                else
                                begin
                                    rc_next = rc_reg + 1'b1;
                                    e_kind  = frl_pkg::KIND_GRANTED;
                                end
                            end
                            else if (q_stat.full)
                            begin
                                e_kind = frl_pkg::KIND_REJECTED;
                            end
                            else
                            begin
                                q_ctrl.push = 1'b1;
                                e_kind      = frl_pkg::KIND_QUEUED;
                            end
                        end
                    end

                    frl_pkg::OP_RELEASE_EXCL:
                    begin
                        if (!wa_reg)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_kind     = frl_pkg::KIND_PROTO_ERR;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            // Drop the writer and start draining
                            wa_next         = 1'b0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_READ;
                        end
                    end

                    frl_pkg::OP_RELEASE_SHARED:
                    begin
                        if (wa_reg || (rc_reg == '0))
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_kind     = frl_pkg::KIND_PROTO_ERR;
                                state_next = S_IDLE;
                            end
                        end
                        else if (rc_reg != frl_pkg::RCNT_W'(1))
                        begin
                            if (out_free)
                            begin
                                rc_next    = rc_reg - 1'b1;
                                emit       = 1'b1;
                                e_kind     = frl_pkg::KIND_NONE;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            // Last shared hold gone: drain
                            rc_next         = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_READ;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            e_kind     = frl_pkg::KIND_PROTO_ERR;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_READ:
            begin
                // Wait for the registered head read
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (cont)
                begin
                    // Pop the head; send the previous waiter as not last
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit   = 1'b1;
                            e_kind = frl_pkg::KIND_RESUMED;
                            e_id   = pend_reg.id;
                            e_excl = pend_reg.excl;
                            e_last = 1'b0;
                        end
                        q_ctrl.pop      = 1'b1;
                        pend_next       = q_head;
                        pend_valid_next = 1'b1;
                        n_next          = n_reg + 1'b1;
                        if (q_head.excl)
                        begin
                            wa_next = 1'b1;
                        end
                        else
                        begin
                            rc_next = rc_reg + 1'b1;
                        end
                        state_next = S_READ;
                    end
                end
                else if (out_free)
                begin
                    // Drain done: close with the held waiter or a none word
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (pend_valid_reg)
                    begin
                        e_kind = frl_pkg::KIND_RESUMED;
                        e_id   = pend_reg.id;
                        e_excl = pend_reg.excl;
                    end
                    else
                    begin
                        e_kind = frl_pkg::KIND_NONE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wa_reg         <= 1'b0;
            rc_reg         <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wa_reg         <= wa_next;
            rc_reg         <= rc_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        req_reg  <= req_next;
        pend_reg <= pend_next;
        if (emit)
        begin
            kind_reg  <= e_kind;
            rid_reg   <= e_id;
            rexcl_reg <= e_excl;
            last_reg  <= e_last;
        end
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign resumed_id        = rid_reg;
    assign resumed_exclusive = rexcl_reg;
    assign last              = last_reg;

    // Checks
    assign chk_depth_ok   = (q_stat.count <= frl_pkg::QCNT_W'(frl_pkg::QUEUE_DEPTH));
    assign chk_plain_word = out_valid_reg && (kind_reg != frl_pkg::KIND_RESUMED);
    assign chk_plain_ok   = (rid_reg == '0) && !rexcl_reg && last_reg;

    `FRL_ASSERT_NOW(a_no_writer_with_readers, wa_reg, rc_reg == '0)
    `FRL_ASSERT_NOW(a_queue_in_range, 1'b1, chk_depth_ok)
    `FRL_ASSERT_NOW(a_id_only_on_resume, chk_plain_word, chk_plain_ok)
    `FRL_ASSERT_NEXT(a_accept_decides, in_valid && !in_stall, state_reg == S_DECIDE)

endmodule

// ===== design/frl_queue.sv =====
// ----------------------------------------------------------------------------
// frl_queue
// Circular wait queue: one write port at the tail, registered read of the
// head entry, pointer and fill-count tracking.
// ----------------------------------------------------------------------------
module frl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  frl_pkg::q_ctrl_t   ctrl,
    input  frl_pkg::q_entry_t  push_entry,
    output frl_pkg::q_entry_t  head_entry,
    output frl_pkg::q_stat_t   stat
);

    frl_pkg::q_entry_t mem [frl_pkg::QUEUE_DEPTH];

    logic [frl_pkg::QIDX_W-1:0] head_reg, head_next;
    logic [frl_pkg::QIDX_W-1:0] tail_reg, tail_next;
    logic [frl_pkg::QCNT_W-1:0] count_reg, count_next;
    frl_pkg::q_entry_t          head_data_reg;

    localparam logic [frl_pkg::QIDX_W-1:0] LAST_IDX =
        frl_pkg::QIDX_W'(frl_pkg::QUEUE_DEPTH - 1);

    // Write at the tail, read the head every cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_entry;
        end
        head_data_reg <= mem[head_reg];
    end

    // Advance pointers with wrap, track fill count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign head_entry  = head_data_reg;
    assign stat.count  = count_reg;
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == frl_pkg::QCNT_W'(frl_pkg::QUEUE_DEPTH));

endmodule

// ===== sim/fifo_fair_reader_writer_lock_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_lock_core_test
// Self-checking bench for the reader-writer lock arbiter. A driver feeds lock
// and release requests from a backlog with random gaps, and a monitor checks
// every result word against a cycle-free model of the lock and its FIFO wait
// queue. A directed opening, then random request batches.
// ----------------------------------------------------------------------------
module fifo_fair_reader_writer_lock_core_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 215;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1500;

    typedef struct packed {
        logic [1:0]               op;
        logic [frl_pkg::ID_W-1:0] id;
        logic                     excl;
    } lock_req_t;

    typedef struct packed {
        frl_pkg::kind_t           kind;
        logic [frl_pkg::ID_W-1:0] id;
        logic                     excl;
        logic                     last;
    } lock_word_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               op = frl_pkg::OP_LOCK;
    logic [frl_pkg::ID_W-1:0] requester_id = '0;
    logic                     want_exclusive = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [2:0]               kind;
    logic [frl_pkg::ID_W-1:0] resumed_id;
    logic                     resumed_exclusive;
    logic                     last;

    // Lock state as seen by the model
    bit                 wr_held;
    int                 rd_holds;
    frl_pkg::q_entry_t  waiters [frl_pkg::QUEUE_DEPTH];
    int                 wq_head;
    int                 wq_tail;
    int                 wq_count;

    lock_req_t   req_backlog [$];
    lock_word_t  due_words [$];
    lock_req_t   offered;
    int          send_wait;
    int          stall_left;
    int          taken_cnt;
    int          hold_at;
    int          idle_cycles = 0;
    int          fault_cnt = 0;
    logic [8:0]  phase_cnt;
    logic        calm;
    logic        hold_on = 1'b0;

    fifo_fair_reader_writer_lock_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .requester_id      (requester_id),
        .want_exclusive    (want_exclusive),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .resumed_id        (resumed_id),
        .resumed_exclusive (resumed_exclusive),
        .last              (last)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Gap length: mostly none, some short, a few long; none in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic lock_word_t make_word(frl_pkg::kind_t k, logic [frl_pkg::ID_W-1:0] rid,
                                             logic x, logic l);
        lock_word_t w;
        w.kind = k;
        w.id   = rid;
        w.excl = x;
        w.last = l;
        return w;
    endfunction

    // Pop waiters in order while they fit: shared ones until a writer fronts,
    // or one writer when nobody holds the lock
    function automatic void resume_waiters();
        lock_word_t        run [$];
        frl_pkg::q_entry_t e;
        bit                stop;
        stop = 1'b0;
        while (!stop && wq_count > 0 && !wr_held && run.size() < frl_pkg::MAX_OUT)
        begin
            e = waiters[wq_head];
            if (e.excl)
            begin
                if (rd_holds != 0)
                    stop = 1'b1;
                else
                    wr_held = 1'b1;
            end
            else
            begin
                if (rd_holds >= frl_pkg::MAX_READERS)
                    stop = 1'b1;
                else
                    rd_holds++;
            end
            if (!stop)
            begin
                wq_head = (wq_head + 1) % frl_pkg::QUEUE_DEPTH;
                wq_count--;
                run.insert(run.size(), make_word(frl_pkg::KIND_RESUMED, e.id, e.excl, 1'b0));
            end
        end
        if (run.size() == 0)
            run.insert(0, make_word(frl_pkg::KIND_NONE, '0, 1'b0, 1'b1));
        else
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            due_words.insert(due_words.size(), run[i]);
    endfunction

    // Queue one expected single-word result
    function automatic void expect_single(frl_pkg::kind_t k);
        due_words.insert(due_words.size(), make_word(k, '0, 1'b0, 1'b1));
    endfunction

    // Advance the lock model by one accepted request and queue its words
    function automatic void predict_lock_words(lock_req_t r);
        case (r.op)
            frl_pkg::OP_LOCK:
            begin
                if (!wr_held && wq_count == 0 && (!r.excl || rd_holds == 0))
                begin
                    if (r.excl)
                    begin
                        wr_held = 1'b1;
                        expect_single(frl_pkg::KIND_GRANTED);
                    end
                    else if (rd_holds >= frl_pkg::MAX_READERS)
                        expect_single(frl_pkg::KIND_REJECTED);
                    else
                    begin
                        rd_holds++;
                        expect_single(frl_pkg::KIND_GRANTED);
                    end
                end
                else if (wq_count >= frl_pkg::QUEUE_DEPTH)
                    expect_single(frl_pkg::KIND_REJECTED);
                else
                begin
                    waiters[wq_tail].excl = r.excl;
                    waiters[wq_tail].id   = r.id;
                    wq_tail = (wq_tail + 1) % frl_pkg::QUEUE_DEPTH;
                    wq_count++;
                    expect_single(frl_pkg::KIND_QUEUED);
                end
            end
            frl_pkg::OP_RELEASE_EXCL:
            begin
                if (!wr_held)
                    expect_single(frl_pkg::KIND_PROTO_ERR);
                else
                begin
                    wr_held = 1'b0;
                    resume_waiters();
                end
            end
            frl_pkg::OP_RELEASE_SHARED:
            begin
                if (wr_held || rd_holds == 0)
                    expect_single(frl_pkg::KIND_PROTO_ERR);
                else
                begin
                    rd_holds--;
                    if (rd_holds != 0)
                        expect_single(frl_pkg::KIND_NONE);
                    else
                        resume_waiters();
                end
            end
            default:
                expect_single(frl_pkg::KIND_PROTO_ERR);
        endcase
    endfunction

    task automatic add_req(logic [1:0] o, logic [frl_pkg::ID_W-1:0] rid, logic x);
        lock_req_t r;
        r.op   = o;
        r.id   = rid;
        r.excl = x;
        req_backlog.insert(req_backlog.size(), r);
    endtask

    // Fill the backlog: directed opening, then random batches
    initial
    begin : build_stimulus
        int        random_cnt;
        int        batch_n;
        logic      x;
        logic      excl_flags [$];
        random_cnt = 0;

        // release errors and the unused op
        add_req(frl_pkg::OP_RELEASE_EXCL, 8'h00, 1'b0);
        add_req(frl_pkg::OP_RELEASE_SHARED, 8'hFF, 1'b1);
        add_req(OP_UNUSED, 8'hFF, 1'b1);
        // reader holds, a writer and a reader wait behind it
        add_req(frl_pkg::OP_LOCK, 8'h00, 1'b0);
        add_req(frl_pkg::OP_LOCK, 8'hFF, 1'b1);
        add_req(frl_pkg::OP_LOCK, 8'h3C, 1'b0);
        // last shared release resumes the writer; shared release under a writer
        add_req(frl_pkg::OP_RELEASE_SHARED, 8'h00, 1'b0);
        add_req(frl_pkg::OP_RELEASE_SHARED, 8'h00, 1'b0);
        // exclusive release resumes the reader, then nobody is left to resume
        add_req(frl_pkg::OP_RELEASE_EXCL, 8'h00, 1'b0);
        add_req(frl_pkg::OP_RELEASE_SHARED, 8'h00, 1'b0);
        // writer holds, fill the queue, overflow it, then drain all of it
        add_req(frl_pkg::OP_LOCK, 8'hA5, 1'b1);
        for (int i = 0; i < frl_pkg::QUEUE_DEPTH; i++)
            add_req(frl_pkg::OP_LOCK, frl_pkg::ID_W'($urandom_range(0, 255)), 1'b0);
        add_req(frl_pkg::OP_LOCK, 8'h81, 1'b1);
        add_req(frl_pkg::OP_RELEASE_EXCL, 8'h00, 1'b0);

        // Drop the drained readers
        repeat (frl_pkg::QUEUE_DEPTH) add_req(frl_pkg::OP_RELEASE_SHARED, 8'h00, 1'b0);
        hold_at = req_backlog.size() + 40;

        // Random batches: a writer, waiters behind it, then matching releases, or one to six random requests
        while (random_cnt < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                batch_n = $urandom_range(0, 18);
                excl_flags.delete();
                add_req(frl_pkg::OP_LOCK, frl_pkg::ID_W'($urandom_range(0, 255)), 1'b1);
                for (int i = 0; i < batch_n; i++)
                begin
                    x = ($urandom_range(0, 3) == 0);
                    excl_flags.insert(excl_flags.size(), x);
                    add_req(frl_pkg::OP_LOCK, frl_pkg::ID_W'($urandom_range(0, 255)), x);
                end
                add_req(frl_pkg::OP_RELEASE_EXCL, frl_pkg::ID_W'($urandom_range(0, 255)),
                        1'($urandom));
                foreach (excl_flags[i])
                    add_req(excl_flags[i] ? frl_pkg::OP_RELEASE_EXCL
                                          : frl_pkg::OP_RELEASE_SHARED,
                            frl_pkg::ID_W'($urandom_range(0, 255)), 1'($urandom));
                random_cnt += 2 + 2 * batch_n;
            end
            else
            begin
                batch_n = $urandom_range(1, 6);
                for (int i = 0; i < batch_n; i++)
                    add_req(2'($urandom_range(0, 3)), frl_pkg::ID_W'($urandom_range(0, 255)),
                            1'($urandom));
                random_cnt += batch_n;
            end
        end
    end

    // Alternate busy stretches with calm ones
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_cnt <= '0;
            calm      <= 1'b0;
        end
        else
        begin
            phase_cnt <= phase_cnt + 1'b1;
            calm      <= (phase_cnt[8:7] == 2'b11);
        end
    end

    // Driver: predict each accepted word, then offer the next after a gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            op             <= frl_pkg::OP_LOCK;
            requester_id   <= '0;
            want_exclusive <= 1'b0;
            send_wait      <= 0;
            taken_cnt      <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_lock_words(offered);
                taken_cnt <= taken_cnt + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    offered = req_backlog[0];
                    req_backlog.delete(0);
                    op             <= offered.op;
                    requester_id   <= offered.id;
                    want_exclusive <= offered.excl;
                    in_valid       <= 1'b1;
                    send_wait      <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stalls: random gaps, plus the long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (stall_left != 0)
                stall_left <= stall_left - 1;
            else if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
            out_stall <= hold_on || (stall_left != 0);
        end
    end

    // Hold the output off long enough for the block to back up its input
    initial
    begin
        while (hold_at == 0 || taken_cnt < hold_at)
            @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Monitor: compare each accepted word with the oldest expected one
    always @(posedge clk)
    begin : check_words
        lock_word_t got;
        lock_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = make_word(frl_pkg::kind_t'(kind), resumed_id, resumed_exclusive, last);
            if (due_words.size() == 0)
            begin
                if (fault_cnt < 10)
                    $display("unexpected word: kind=%0d id=%0h excl=%0b last=%0b",
                             got.kind, got.id, got.excl, got.last);
                fault_cnt++;
            end
            else
            begin
                want = due_words[0];
                due_words.delete(0);
                if (got !== want)
                begin
                    if (fault_cnt < 10)
                        $display({"word mismatch: expected kind=%0d id=%0h excl=%0b last=%0b,",
                                  " got kind=%0d id=%0h excl=%0b last=%0b"},
                                 want.kind, want.id, want.excl, want.last,
                                 got.kind, got.id, got.excl, got.last);
                    fault_cnt++;
                end
            end
        end
    end

    // Count cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
    end

    // Wait out the backlog and all expected words, then report
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_cnt == 0 && due_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
